[rtl/fbbm_pkg.sv]
// Shared constants, command codes and interface types for the block buffer map.
`default_nettype none

package fbbm_pkg;

    // Defaults for the top-level parameters
    localparam int NUM_SLOTS_DEF     = 16;
    localparam int NUM_BLOCK_IDS_DEF = 1024;

    // Fixed field widths of the item ports and the slot count register
    localparam int CMD_W      = 2;
    localparam int BID_W      = 10;
    localparam int SLOT_OUT_W = 4;
    localparam int CFG_W      = 5;

    // Largest slot count a command may use
    localparam int SLOT_CAP = 16;

    // Reset value of the slot count register
    localparam logic [CFG_W-1:0] SLOTS_IN_USE_RST = 5'd16;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_GET_READ  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_GET_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FLUSH     = 2'd2;

    // Register index of the slot count register
    localparam logic REG_SLOTS_IN_USE = 1'b0;

    // Access strobes toward the id map
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } idm_ctl_t;

endpackage : fbbm_pkg

`default_nettype wire

[rtl/fbbm_id_map.sv]
// Block id to slot map: one synchronous memory with a clearing sweep after reset.
`default_nettype none

module fbbm_id_map
    import fbbm_pkg::*;
#(
    parameter int NUM_SLOTS     = NUM_SLOTS_DEF,
    parameter int NUM_BLOCK_IDS = NUM_BLOCK_IDS_DEF
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire idm_ctl_t                         ctl,
    input  wire logic [$clog2(NUM_BLOCK_IDS)-1:0] addr,
    input  wire logic [$clog2(NUM_SLOTS)-1:0]     wr_data,
    output logic      [$clog2(NUM_SLOTS)-1:0]     rd_data,
    output logic                                  busy
);

    localparam int ID_W   = $clog2(NUM_BLOCK_IDS);
    localparam int SLOT_W = $clog2(NUM_SLOTS);

    logic [SLOT_W-1:0] map_mem [NUM_BLOCK_IDS];
    logic [ID_W:0]     clr_cnt_reg;
    logic [ID_W:0]     clr_cnt_next;
    logic [SLOT_W-1:0] rd_data_reg;

    // Sweep every entry once after reset; entries then read as slot zero,
    // which the owner check of the caller rejects unless it truly matches
    assign busy = (clr_cnt_reg != (ID_W+1)'(NUM_BLOCK_IDS));

    always_comb
    begin
        clr_cnt_next = clr_cnt_reg;
        if (busy)
        begin
            clr_cnt_next = clr_cnt_reg + (ID_W+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // Write port: sweep first, then mapping updates
    always_ff @(posedge clk)
    begin
        if (busy)
        begin
            map_mem[clr_cnt_reg[ID_W-1:0]] <= '0;
        end
        else if (ctl.wr_en)
        begin
            map_mem[addr] <= wr_data;
        end
    end

    // Read port with registered data; hold data between reads
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data_reg <= map_mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule : fbbm_id_map

`default_nettype wire

[rtl/fifo_block_buffer_map.sv]
// Get hit: the id map read, then the owner table read, then the result register.
// Get miss: as a hit, but the victim owner is read before the result register.
// Flush: each used slot in range is read from the owner table and emitted; empty slots
// ahead of the last used one are stepped over; a stalled result holds the sequencer.
// One item at a time: a new item is taken only once the sequencer is back in idle.
// After reset the id map sweeps every entry before the first item is taken.
`default_nettype none

module fifo_block_buffer_map
    import fbbm_pkg::*;
#(
    parameter int NUM_SLOTS     = NUM_SLOTS_DEF,
    parameter int NUM_BLOCK_IDS = NUM_BLOCK_IDS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [2:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready,
    // request channel
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [CMD_W-1:0]      command,
    input  wire logic [BID_W-1:0]      block_id,
    input  wire logic                  skip_read,
    // result channel
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic                       hit,
    output logic [SLOT_OUT_W-1:0]      slot,
    output logic                       fetch,
    output logic                       write_back,
    output logic [BID_W-1:0]           write_back_id,
    output logic                       last
);

    localparam int ID_W   = $clog2(NUM_BLOCK_IDS);
    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam int CMP_W  = (SLOT_W + 1 > CFG_W + 1) ? SLOT_W + 1 : CFG_W + 1;
    localparam int NMAX   = (NUM_SLOTS < SLOT_CAP) ? NUM_SLOTS : SLOT_CAP;
    localparam int RED_W  = 17;
    localparam int KMAX   = BID_W - 1;
    localparam bit ID_POW2 = ((NUM_BLOCK_IDS & (NUM_BLOCK_IDS - 1)) == 0);

    // Sequencer states
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_OWN_RD  = 3'd1;
    localparam logic [2:0] S_CHECK   = 3'd2;
    localparam logic [2:0] S_EVICT   = 3'd3;
    localparam logic [2:0] S_FL_RD   = 3'd4;
    localparam logic [2:0] S_FL_EMIT = 3'd5;

    // Configuration
    logic [CFG_W-1:0]  slots_in_use_reg;
    logic              cfg_wr;
    logic [CMP_W-1:0]  n_cur;

    // Sequencer and item registers
    logic [2:0]        state_reg, state_next;
    logic [CMD_W-1:0]  cmd_reg, cmd_next;
    logic [ID_W-1:0]   bid_reg, bid_next;
    logic              skip_reg, skip_next;
    logic [SLOT_W-1:0] s_reg, s_next;
    logic [SLOT_W-1:0] v_reg, v_next;
    logic              fp_eff_reg, fp_eff_next;
    logic [CMP_W-1:0]  idx_reg, idx_next;
    logic [CMP_W-1:0]  end_reg, end_next;

    // Replacement state
    logic [SLOT_W-1:0] ptr_reg, ptr_next;
    logic              fp_reg, fp_next;

    // Owner table: ids in memory, valid bits in flops
    logic [ID_W-1:0]      owner_mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] owner_valid_reg, owner_valid_next;
    logic                 own_rd_en;
    logic [SLOT_W-1:0]    own_rd_addr;
    logic [ID_W-1:0]      own_rd_data_reg;
    logic                 own_wr_en;

    // Id map
    idm_ctl_t          idm_ctl;
    logic [ID_W-1:0]   idm_addr;
    logic [SLOT_W-1:0] idm_rd_data;
    logic              idm_busy;

    // Result register
    logic                  out_valid_reg, out_valid_next;
    logic                  hit_reg, hit_next;
    logic [SLOT_OUT_W-1:0] slot_reg, slot_next;
    logic                  fetch_reg, fetch_next;
    logic                  wb_reg, wb_next;
    logic [BID_W-1:0]      wb_id_reg, wb_id_next;
    logic                  last_reg, last_next;

    // Helpers
    logic [ID_W-1:0]   bid_red;
    logic [RED_W-1:0]  rem;
    logic              accept;
    logic              can_emit;
    logic              own_hit;
    logic              wrap;
    logic [CMP_W-1:0]  ptr_ext;
    logic [CMP_W-1:0]  v_inc;
    logic              more;

    // ---------------------------------------------------------------
    // Configuration port
    // ---------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_in_use_reg <= SLOTS_IN_USE_RST;
        end
        else if (cfg_wr && (paddr[2] == REG_SLOTS_IN_USE))
        begin
            slots_in_use_reg <= pwdata[CFG_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_SLOTS_IN_USE)
        begin
            prdata = 32'(slots_in_use_reg);
        end
    end

    // Clamp the slot count to one .. NMAX
    always_comb
    begin
        if (slots_in_use_reg == '0)
        begin
            n_cur = CMP_W'(1);
        end
        else if (CMP_W'(slots_in_use_reg) > CMP_W'(NMAX))
        begin
            n_cur = CMP_W'(NMAX);
        end
        else
        begin
            n_cur = CMP_W'(slots_in_use_reg);
        end
    end

    // ---------------------------------------------------------------
    // Reduce the requested id into the id range
    // ---------------------------------------------------------------
    generate
        if (ID_POW2)
        begin : g_red_mask
            assign rem     = '0;
            assign bid_red = ID_W'(block_id);
        end
        else
        begin : g_red_sub
            always_comb
            begin
                rem = RED_W'(block_id);
                for (int k = KMAX; k >= 0; k--)
                begin
                    if ((NUM_BLOCK_IDS << k) < (1 << BID_W))
                    begin
                        if (rem >= RED_W'(NUM_BLOCK_IDS << k))
                        begin
                            rem = rem - RED_W'(NUM_BLOCK_IDS << k);
                        end
                    end
                end
            end
            assign bid_red = ID_W'(rem);
        end
    endgenerate

    // ---------------------------------------------------------------
    // Id map
    // ---------------------------------------------------------------
    fbbm_id_map #(
        .NUM_SLOTS     (NUM_SLOTS),
        .NUM_BLOCK_IDS (NUM_BLOCK_IDS)
    ) u_id_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (idm_ctl),
        .addr    (idm_addr),
        .wr_data (v_reg),
        .rd_data (idm_rd_data),
        .busy    (idm_busy)
    );

    // ---------------------------------------------------------------
    // Owner table memory
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (own_wr_en)
        begin
            owner_mem[v_reg] <= bid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (own_rd_en)
        begin
            own_rd_data_reg <= owner_mem[own_rd_addr];
        end
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    assign in_ready = (state_reg == S_IDLE) && !idm_busy;
    assign accept   = in_valid && in_ready;
    assign can_emit = !out_valid_reg || out_ready;

    // Stored entry still owned by the requested id
    assign own_hit = owner_valid_reg[s_reg] && (own_rd_data_reg == bid_reg);

    // Victim choice: wrap the pointer when the slot count shrank to or below it
    assign ptr_ext = CMP_W'(ptr_reg);
    assign wrap    = (ptr_ext >= n_cur);
    assign v_inc   = CMP_W'(v_reg) + CMP_W'(1);

    // Any used slot left in the flush range after the current one
    always_comb
    begin
        more = 1'b0;
        for (int j = 0; j < NUM_SLOTS; j++)
        begin
            if (owner_valid_reg[j] && (CMP_W'(j) > idx_reg) && (CMP_W'(j) < end_reg))
            begin
                more = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        bid_next         = bid_reg;
        skip_next        = skip_reg;
        s_next           = s_reg;
        v_next           = v_reg;
        fp_eff_next      = fp_eff_reg;
        idx_next         = idx_reg;
        end_next         = end_reg;
        ptr_next         = ptr_reg;
        fp_next          = fp_reg;
        owner_valid_next = owner_valid_reg;
        own_rd_en        = 1'b0;
        own_rd_addr      = s_reg;
        own_wr_en        = 1'b0;
        idm_ctl          = '0;
        idm_addr         = bid_reg;

        // Drop a delivered item from the result register
        out_valid_next = out_valid_reg && !out_ready;
        hit_next       = hit_reg;
        slot_next      = slot_reg;
        fetch_next     = fetch_reg;
        wb_next        = wb_reg;
        wb_id_next     = wb_id_reg;
        last_next      = last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next  = command;
                    bid_next  = bid_red;
                    skip_next = skip_read;
                    if ((command == CMD_GET_READ) || (command == CMD_GET_WRITE))
                    begin
                        idm_ctl.rd_en = 1'b1;
                        idm_addr      = bid_red;
                        state_next    = S_OWN_RD;
                    end
                    else if (command == CMD_FLUSH)
                    begin
                        idx_next = '0;
                        if (fp_reg)
                        begin
                            end_next = (ptr_ext > n_cur) ? n_cur : ptr_ext;
                        end
                        else
                        begin
                            end_next = n_cur;
                        end
                        state_next = S_FL_RD;
                    end
                end
            end

            S_OWN_RD:
            begin
                // Look up the owner of the slot the id map points at
                own_rd_en   = 1'b1;
                own_rd_addr = idm_rd_data;
                s_next      = idm_rd_data;
                state_next  = S_CHECK;
            end

            S_CHECK:
            begin
                if (own_hit)
                begin
                    if (can_emit)
                    begin
                        out_valid_next = 1'b1;
                        hit_next       = 1'b1;
                        slot_next      = SLOT_OUT_W'(s_reg);
                        fetch_next     = 1'b0;
                        wb_next        = 1'b0;
                        wb_id_next     = '0;
                        last_next      = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    // Miss: read the victim's owner
                    v_next      = wrap ? '0 : ptr_reg;
                    fp_eff_next = wrap ? 1'b0 : fp_reg;
                    own_rd_en   = 1'b1;
                    own_rd_addr = wrap ? '0 : ptr_reg;
                    state_next  = S_EVICT;
                end
            end

            S_EVICT:
            begin
                if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    hit_next       = 1'b0;
                    slot_next      = SLOT_OUT_W'(v_reg);
                    fetch_next     = (cmd_reg == CMD_GET_READ) || !skip_reg;
                    wb_next        = (cmd_reg == CMD_GET_WRITE) && !fp_eff_reg
                                     && owner_valid_reg[v_reg];
                    wb_id_next     = wb_next ? BID_W'(own_rd_data_reg) : '0;
                    last_next      = 1'b1;

                    // Map the new block into the victim slot
                    own_wr_en               = 1'b1;
                    owner_valid_next[v_reg] = 1'b1;
                    idm_ctl.wr_en           = 1'b1;
                    idm_addr                = bid_reg;

                    // Advance the round-robin pointer
                    if (v_inc >= n_cur)
                    begin
                        ptr_next = '0;
                        fp_next  = 1'b0;
                    end
                    else
                    begin
                        ptr_next = SLOT_W'(v_inc);
                        fp_next  = fp_eff_reg;
                    end
                    state_next = S_IDLE;
                end
            end

            S_FL_RD:
            begin
                if (idx_reg >= end_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (owner_valid_reg[idx_reg[SLOT_W-1:0]])
                begin
                    own_rd_en   = 1'b1;
                    own_rd_addr = idx_reg[SLOT_W-1:0];
                    state_next  = S_FL_EMIT;
                end
                else
                begin
                    idx_next = idx_reg + CMP_W'(1);
                end
            end

            S_FL_EMIT:
            begin
                if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    hit_next       = 1'b0;
                    slot_next      = SLOT_OUT_W'(idx_reg);
                    fetch_next     = 1'b0;
                    wb_next        = 1'b1;
                    wb_id_next     = BID_W'(own_rd_data_reg);
                    last_next      = !more;

                    // Unmap the slot; the id map entry dies with the owner
                    owner_valid_next[idx_reg[SLOT_W-1:0]] = 1'b0;
                    idx_next   = idx_reg + CMP_W'(1);
                    state_next = more ? S_FL_RD : S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            ptr_reg         <= '0;
            fp_reg          <= 1'b1;
            owner_valid_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            ptr_reg         <= ptr_next;
            fp_reg          <= fp_next;
            owner_valid_reg <= owner_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        bid_reg    <= bid_next;
        skip_reg   <= skip_next;
        s_reg      <= s_next;
        v_reg      <= v_next;
        fp_eff_reg <= fp_eff_next;
        idx_reg    <= idx_next;
        end_reg    <= end_next;
        hit_reg    <= hit_next;
        slot_reg   <= slot_next;
        fetch_reg  <= fetch_next;
        wb_reg     <= wb_next;
        wb_id_reg  <= wb_id_next;
        last_reg   <= last_next;
    end

    assign out_valid     = out_valid_reg;
    assign hit           = hit_reg;
    assign slot          = slot_reg;
    assign fetch         = fetch_reg;
    assign write_back    = wb_reg;
    assign write_back_id = wb_id_reg;
    assign last          = last_reg;

endmodule : fifo_block_buffer_map

`default_nettype wire

[sim/tb.sv]
// Self-checking bench for the block buffer map: scoreboarded random gets and flushes.
`default_nettype none

module tb;
    import fbbm_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED     = 2'd3;
    localparam logic [2:0] SLOT_COUNT_ADDR      = 3'(4 * int'(REG_SLOTS_IN_USE));
    localparam int         HOT_IDS              = 20;
    localparam int         SETTLE_CYCLES        = 64;
    localparam int         CYCLE_LIMIT          = 400000;
    localparam int         REPORT_MAX           = 10;

    // One result item of the block
    typedef struct packed {
        logic             hit;
        logic [3:0]       slot;
        logic             fetch;
        logic             write_back;
        logic [BID_W-1:0] write_back_id;
        logic             last;
    } reply_t;

    // Tracks both maps and the pointer, and holds the replies still owed
    class pool_tracker;
        bit               id_present [NUM_BLOCK_IDS_DEF];
        logic [3:0]       id_slot    [NUM_BLOCK_IDS_DEF];
        bit               owner_present [NUM_SLOTS_DEF];
        logic [BID_W-1:0] owner_id      [NUM_SLOTS_DEF];
        int unsigned      rptr;
        bit               first_pass;
        logic [CFG_W-1:0] slot_count_reg;
        reply_t           pending_replies[$];
        int unsigned      errors;

        function new();
            foreach (id_present[i]) begin
                id_present[i] = 1'b0;
                id_slot[i]    = '0;
            end
            foreach (owner_present[i]) begin
                owner_present[i] = 1'b0;
                owner_id[i]      = '0;
            end
            rptr           = 0;
            first_pass     = 1'b1;
            slot_count_reg = SLOTS_IN_USE_RST;
            errors         = 0;
        endfunction

        function void set_slot_count(logic [CFG_W-1:0] value);
            slot_count_reg = value;
        endfunction

        // Clamp the register to the usable slot range
        function int unsigned active_slots();
            int unsigned n;
            n = slot_count_reg;
            if (n < 1) n = 1;
            if (n > NUM_SLOTS_DEF) n = NUM_SLOTS_DEF;
            if (n > SLOT_CAP) n = SLOT_CAP;
            return n;
        endfunction

        function void note_error(string msg);
            if (errors < REPORT_MAX)
                $display("mismatch: %s", msg);
            errors++;
        endfunction

        // Update the maps for one accepted item and queue the replies it causes
        function void take_request(logic [CMD_W-1:0] cmd, logic [BID_W-1:0] bid,
                                   logic skip);
            int unsigned n;
            int unsigned v;
            int unsigned end_slot;
            int          first_idx;
            bit          had_owner;
            logic [BID_W-1:0] old_id;
            reply_t      r;
            n = active_slots();
            r = '0;
            if (cmd == CMD_GET_READ || cmd == CMD_GET_WRITE) begin
                if (id_present[bid]) begin
                    r.hit  = 1'b1;
                    r.slot = id_slot[bid];
                    r.last = 1'b1;
                    pending_replies.push_back(r);
                    return;
                end
                // wrap a pointer left out of range by a lowered slot count
                if (rptr >= n) begin
                    rptr       = 0;
                    first_pass = 1'b0;
                end
                v         = rptr;
                had_owner = owner_present[v];
                old_id    = owner_id[v];
                if (had_owner)
                    id_present[old_id] = 1'b0;
                if (cmd == CMD_GET_WRITE && !first_pass && had_owner) begin
                    r.write_back    = 1'b1;
                    r.write_back_id = old_id;
                end
                r.fetch = (cmd == CMD_GET_READ) ? 1'b1 : !skip;
                id_present[bid] = 1'b1;
                id_slot[bid]    = 4'(v);
                owner_present[v] = 1'b1;
                owner_id[v]      = bid;
                rptr = v + 1;
                if (rptr >= n) begin
                    rptr       = 0;
                    first_pass = 1'b0;
                end
                r.slot = 4'(v);
                r.last = 1'b1;
                pending_replies.push_back(r);
            end else if (cmd == CMD_FLUSH) begin
                end_slot  = first_pass ? rptr : n;
                if (end_slot > n) end_slot = n;
                first_idx = pending_replies.size();
                for (int i = 0; i < int'(end_slot); i++) begin
                    if (owner_present[i]) begin
                        r               = '0;
                        r.slot          = 4'(i);
                        r.write_back    = 1'b1;
                        r.write_back_id = owner_id[i];
                        pending_replies.push_back(r);
                        id_present[owner_id[i]] = 1'b0;
                        owner_present[i] = 1'b0;
                        owner_id[i]      = '0;
                    end
                end
                if (pending_replies.size() > first_idx)
                    pending_replies[pending_replies.size() - 1].last = 1'b1;
            end
        endfunction

        // Compare one accepted result with the oldest owed reply
        function void match_reply(reply_t got);
            reply_t want;
            if (pending_replies.size() == 0) begin
                note_error($sformatf("unexpected result hit=%0d slot=%0d fetch=%0d wb=%0d id=%0d last=%0d",
                                     got.hit, got.slot, got.fetch, got.write_back,
                                     got.write_back_id, got.last));
                return;
            end
            want = pending_replies.pop_front();
            if (got.hit !== want.hit || got.slot !== want.slot ||
                got.fetch !== want.fetch || got.write_back !== want.write_back ||
                got.write_back_id !== want.write_back_id || got.last !== want.last)
                note_error($sformatf("exp hit=%0d slot=%0d fetch=%0d wb=%0d id=%0d last=%0d, got hit=%0d slot=%0d fetch=%0d wb=%0d id=%0d last=%0d",
                                     want.hit, want.slot, want.fetch, want.write_back,
                                     want.write_back_id, want.last,
                                     got.hit, got.slot, got.fetch, got.write_back,
                                     got.write_back_id, got.last));
        endfunction
    endclass

    logic             clk     = 1'b0;
    logic             rst_n   = 1'b0;
    logic             psel    = 1'b0;
    logic             penable = 1'b0;
    logic             pwrite  = 1'b0;
    logic [2:0]       paddr   = '0;
    logic [31:0]      pwdata  = '0;
    logic [31:0]      prdata;
    logic             pready;
    logic             in_valid  = 1'b0;
    logic             in_ready;
    logic [CMD_W-1:0] command   = '0;
    logic [BID_W-1:0] block_id  = '0;
    logic             skip_read = 1'b0;
    logic             out_valid;
    logic             out_ready = 1'b1;
    logic             hit;
    logic [SLOT_OUT_W-1:0] slot;
    logic             fetch;
    logic             write_back;
    logic [BID_W-1:0] write_back_id;
    logic             last;

    pool_tracker      tracker;
    logic [BID_W-1:0] hot_ids [HOT_IDS];
    bit               in_idle_on   = 1'b0;
    bit               out_stall_on = 1'b0;
    int unsigned      stall_left   = 0;
    int unsigned      cycle_count  = 0;

    fifo_block_buffer_map u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .block_id      (block_id),
        .skip_read     (skip_read),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .hit           (hit),
        .slot          (slot),
        .fetch         (fetch),
        .write_back    (write_back),
        .write_back_id (write_back_id),
        .last          (last)
    );

    always #1 clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Check accepted results and stall the result channel in bursts
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.match_reply({hit, slot, fetch, write_back, write_back_id, last});
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else if (out_stall_on && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 8);
            out_ready  <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // Offer one item, optionally after an idle burst, and hold it until taken
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [BID_W-1:0] bid,
                             input logic skip);
        int unsigned gap;
        gap = 0;
        if (in_idle_on && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 9);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        command   <= cmd;
        block_id  <= bid;
        skip_read <= skip;
        do
            @(posedge clk);
        while (!in_ready);
        tracker.take_request(cmd, bid, skip);
    endtask

    // Drop valid, wait for every owed reply, then let the block settle
    task automatic drain();
        in_valid <= 1'b0;
        while (tracker.pending_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write of the slot count: a setup phase, then an access phase until ready
    task automatic write_slot_count(input logic [CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SLOT_COUNT_ADDR;
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.set_slot_count(value);
    endtask

    // Mostly gets on a small id set so hits and evictions both occur
    task automatic random_item();
        int unsigned      roll;
        logic [CMD_W-1:0] cmd;
        logic [BID_W-1:0] bid;
        roll = $urandom_range(0, 99);
        if (roll < 42)      cmd = CMD_GET_READ;
        else if (roll < 88) cmd = CMD_GET_WRITE;
        else if (roll < 96) cmd = CMD_FLUSH;
        else                cmd = CMD_UNUSED;
        if ($urandom_range(0, 3) == 0)
            bid = BID_W'($urandom_range(0, NUM_BLOCK_IDS_DEF - 1));
        else
            bid = hot_ids[$urandom_range(0, HOT_IDS - 1)];
        send_item(cmd, bid, 1'($urandom_range(0, 1)));
    endtask

    // One setting of the slot count with a fresh id set
    task automatic run_phase(input logic [CFG_W-1:0] count, input int unsigned items,
                             input bit quiet);
        write_slot_count(count);
        foreach (hot_ids[i])
            hot_ids[i] = BID_W'($urandom_range(0, NUM_BLOCK_IDS_DEF - 1));
        in_idle_on   = !quiet && ($urandom_range(0, 3) != 0);
        out_stall_on = !quiet && ($urandom_range(0, 3) != 0);
        repeat (items) random_item();
        drain();
    endtask

    initial
    begin
        tracker = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: four slots, first pass, wrap, write-back, flushes
        write_slot_count(5'd4);
        send_item(CMD_FLUSH,     10'd0,     1'b0);
        send_item(CMD_GET_READ,  10'd0,     1'b1);
        send_item(CMD_GET_READ,  10'd0,     1'b0);
        send_item(CMD_GET_WRITE, 10'd1023,  1'b1);
        send_item(CMD_GET_WRITE, 10'h155,   1'b0);
        send_item(CMD_FLUSH,     10'd0,     1'b0);
        send_item(CMD_GET_READ,  10'h2AA,   1'b1);
        send_item(CMD_GET_WRITE, 10'h155,   1'b0);
        send_item(CMD_GET_WRITE, 10'd1,     1'b1);
        send_item(CMD_GET_WRITE, 10'd2,     1'b0);
        send_item(CMD_GET_WRITE, 10'd3,     1'b0);
        send_item(CMD_GET_WRITE, 10'd2,     1'b1);
        send_item(CMD_UNUSED,    10'd1023,  1'b1);
        send_item(CMD_GET_READ,  10'd1023,  1'b0);
        send_item(CMD_FLUSH,     10'h3FF,   1'b1);
        send_item(CMD_GET_WRITE, 10'd1023,  1'b0);
        drain();

        // Directed: slot count lowered under the pointer
        write_slot_count(5'd1);
        send_item(CMD_GET_WRITE, 10'd7,     1'b0);
        send_item(CMD_GET_WRITE, 10'd8,     1'b1);
        send_item(CMD_GET_READ,  10'd8,     1'b0);
        send_item(CMD_FLUSH,     10'd0,     1'b0);
        send_item(CMD_FLUSH,     10'd0,     1'b0);
        send_item(CMD_GET_READ,  10'h200,   1'b0);
        drain();

        // Random phases across the slot count range
        run_phase(5'd16, 45, 1'b0);
        run_phase(5'd1,  30, 1'b0);
        run_phase(5'd7,  45, 1'b0);
        run_phase(5'd0,  30, 1'b0);
        run_phase(5'd31, 40, 1'b0);
        run_phase(5'd2,  40, 1'b0);
        run_phase(5'd11, 45, 1'b0);
        run_phase(5'd16, 60, 1'b1);

        if (tracker.errors == 0 && tracker.pending_replies.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire

[fifo_block_buffer_map.f]
rtl/fbbm_pkg.sv
rtl/fbbm_id_map.sv
rtl/fifo_block_buffer_map.sv
sim/tb.sv
